/* rtl/hep_pkg.sv */
// ----------------------------------------------------------------------------
// Hunk executable parser package
// Shared types, phase codes, action and error codes, and hunk type numbers.
// ----------------------------------------------------------------------------
package hep_pkg;

	localparam int unsigned MAX_HUNKS  = 256;
	localparam int unsigned HUNK_LIMIT = (MAX_HUNKS < 256) ? MAX_HUNKS : 256;

	typedef enum logic [26:0] {
		PH_MAGIC    = 27'd1 << 0,
		PH_RESLIB   = 27'd1 << 1,
		PH_TSIZE    = 27'd1 << 2,
		PH_TFLAGS   = 27'd1 << 3,
		PH_FIRST    = 27'd1 << 4,
		PH_LAST     = 27'd1 << 5,
		PH_ASIZE    = 27'd1 << 6,
		PH_AFLAGS   = 27'd1 << 7,
		PH_TYPE     = 27'd1 << 8,
		PH_SKIP     = 27'd1 << 9,
		PH_NAMELEN  = 27'd1 << 10,
		PH_SYMLEN   = 27'd1 << 11,
		PH_SYMVAL   = 27'd1 << 12,
		PH_SEGSIZE  = 27'd1 << 13,
		PH_SEGFLAGS = 27'd1 << 14,
		PH_LOAD     = 27'd1 << 15,
		PH_R32COUNT = 27'd1 << 16,
		PH_R32FLAGS = 27'd1 << 17,
		PH_R32REF   = 27'd1 << 18,
		PH_R32OFF   = 27'd1 << 19,
		PH_SCOUNT   = 27'd1 << 20,
		PH_SREF     = 27'd1 << 21,
		PH_SOFF     = 27'd1 << 22,
		PH_SPAD     = 27'd1 << 23,
		PH_DBGSIZE  = 27'd1 << 24,
		PH_DBGFLAGS = 27'd1 << 25,
		PH_HALT     = 27'd1 << 26
	} phase_t;

	typedef enum logic [2:0] {
		ACT_ALLOC  = 3'd0,
		ACT_LOAD   = 3'd1,
		ACT_CLEAR  = 3'd2,
		ACT_PATCH  = 3'd3,
		ACT_FINISH = 3'd4,
		ACT_ERROR  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_MAGIC    = 3'd1,
		ERR_RESLIB   = 3'd2,
		ERR_UNKNOWN  = 3'd3,
		ERR_UNSUPP   = 3'd4,
		ERR_RANGE    = 3'd5
	} error_t;

	localparam logic [31:0] HUNK_MAGIC = 32'h0000_03F3;
	localparam logic [31:0] SIZE_MASK  = 32'h3FFF_FFFF;

	// Hunk type numbers after masking.
	localparam logic [31:0] HT_UNIT     = 32'd999;
	localparam logic [31:0] HT_NAME     = 32'd1000;
	localparam logic [31:0] HT_CODE     = 32'd1001;
	localparam logic [31:0] HT_DATA     = 32'd1002;
	localparam logic [31:0] HT_BSS      = 32'd1003;
	localparam logic [31:0] HT_RELOC32  = 32'd1004;
	localparam logic [31:0] HT_RELOC16  = 32'd1005;
	localparam logic [31:0] HT_RELOC8   = 32'd1006;
	localparam logic [31:0] HT_EXT      = 32'd1007;
	localparam logic [31:0] HT_SYMBOL   = 32'd1008;
	localparam logic [31:0] HT_DEBUG    = 32'd1009;
	localparam logic [31:0] HT_END      = 32'd1010;
	localparam logic [31:0] HT_HEADER   = 32'd1011;
	localparam logic [31:0] HT_OVERLAY  = 32'd1013;
	localparam logic [31:0] HT_BREAK    = 32'd1014;
	localparam logic [31:0] HT_DREL32   = 32'd1015;
	localparam logic [31:0] HT_DREL16   = 32'd1016;
	localparam logic [31:0] HT_DREL8    = 32'd1017;
	localparam logic [31:0] HT_LIB      = 32'd1018;
	localparam logic [31:0] HT_INDEX    = 32'd1019;
	localparam logic [31:0] HT_RELOC32S = 32'd1020;
	localparam logic [31:0] HT_RELRELOC = 32'd1021;
	localparam logic [31:0] HT_MAX      = 32'd1022;

	localparam logic [4:0] KIND_BSS    = 5'd4;
	localparam logic [4:0] KIND_SYMBOL = 5'd9;
	localparam logic [4:0] KIND_DEBUG  = 5'd10;

endpackage

/* rtl/hunk_executable_parser.sv */
// ----------------------------------------------------------------------------
// Hunk executable parser
// Turns a halfword stream of a hunk executable into host load actions.
// ----------------------------------------------------------------------------
// An action is registered: it is at the outputs in the cycle after its halfword is accepted.
// Throughput: one halfword per cycle unless a held action is not taken;
// the parse state update is a single register step, and in_ready falls while it waits.
// Reset: arst_n clears the parse state to expect the header magic and
// empties the output register. After a finish or an error all further
// halfwords are consumed silently until the next reset.
module hunk_executable_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] half_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [7:0]  hunk_number,
	output logic [7:0]  ref_hunk,
	output logic [31:0] byte_offset,
	output logic [31:0] data_value,
	output logic [31:0] mem_flags,
	output logic [2:0]  error_code
);

	// Parse state registers.
	hep_pkg::phase_t phase_q, phase_d;
	logic [15:0] high_q, high_d;
	logic        parity_q, parity_d;
	logic [31:0] remain_q, remain_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  last_q, last_d;
	logic [7:0]  load_q, load_d;
	logic [7:0]  patch_q, patch_d;
	logic [7:0]  pref_q, pref_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] pend_q, pend_d;
	logic        spar_q, spar_d;
	logic [4:0]  kind_q, kind_d;
	logic        used_q, used_d;

	// Result of the current transaction.
	logic        emit;
	logic [2:0]  e_act, e_err;
	logic [7:0]  e_hunk, e_ref;
	logic [31:0] e_off, e_data, e_flags;

	// Output register.
	logic        out_valid_q;
	logic [2:0]  act_q, err_q;
	logic [7:0]  hunk_q, ref_q;
	logic [31:0] off_q, data_q, flags_q;

	logic        accept;
	logic [31:0] v, t, rem_dec, hw32;
	logic        ext;
	logic        short_ph;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// The assembled long is the stored high half followed by the new one.
	assign v        = {high_q, half_word};
	assign hw32     = {16'd0, half_word};
	assign ext      = (v[31:30] == 2'b11);
	assign t        = v & hep_pkg::SIZE_MASK;
	assign rem_dec  = remain_q - 32'd1;
	assign short_ph = (phase_q == hep_pkg::PH_SCOUNT) || (phase_q == hep_pkg::PH_SREF) ||
		(phase_q == hep_pkg::PH_SOFF) || (phase_q == hep_pkg::PH_SPAD);

	always_comb begin
		phase_d  = phase_q;
		high_d   = high_q;
		parity_d = parity_q;
		remain_d = remain_q;
		first_d  = first_q;
		last_d   = last_q;
		load_d   = load_q;
		patch_d  = patch_q;
		pref_d   = pref_q;
		offset_d = offset_q;
		pend_d   = pend_q;
		spar_d   = spar_q;
		kind_d   = kind_q;
		used_d   = used_q;
		emit     = 1'b0;
		e_act    = hep_pkg::ACT_ERROR;
		e_err    = hep_pkg::ERR_NONE;
		e_hunk   = 8'd0;
		e_ref    = 8'd0;
		e_off    = 32'd0;
		e_data   = 32'd0;
		e_flags  = 32'd0;

		if (phase_q == hep_pkg::PH_HALT) begin
			// Finished or failed: swallow everything.
		end else if (short_ph) begin
			// Short relocation hunks are read halfword by halfword.
			spar_d = !spar_q;
			case (phase_q)
				hep_pkg::PH_SCOUNT: begin
					if (half_word == 16'd0) begin
						phase_d = spar_d ? hep_pkg::PH_SPAD : hep_pkg::PH_TYPE;
					end else begin
						remain_d = hw32;
						phase_d  = hep_pkg::PH_SREF;
					end
				end
				hep_pkg::PH_SREF: begin
					if (hw32 < {24'd0, first_q} || hw32 > {24'd0, last_q}) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_RANGE;
					end else begin
						pref_d  = half_word[7:0];
						phase_d = hep_pkg::PH_SOFF;
					end
				end
				hep_pkg::PH_SOFF: begin
					remain_d = rem_dec;
					if (rem_dec == 32'd0) begin
						phase_d = hep_pkg::PH_SCOUNT;
					end
					emit   = 1'b1;
					e_act  = hep_pkg::ACT_PATCH;
					e_hunk = patch_q;
					e_ref  = pref_q;
					e_off  = hw32;
				end
				default: begin
					phase_d = hep_pkg::PH_TYPE;
				end
			endcase
		end else if (!parity_q) begin
			high_d   = half_word;
			parity_d = 1'b1;
		end else begin
			parity_d = 1'b0;
			case (phase_q)
				hep_pkg::PH_MAGIC: begin
					if (v != hep_pkg::HUNK_MAGIC) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_MAGIC;
					end else begin
						phase_d = hep_pkg::PH_RESLIB;
					end
				end
				hep_pkg::PH_RESLIB: begin
					if (v != 32'd0) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_RESLIB;
					end else begin
						phase_d = hep_pkg::PH_TSIZE;
					end
				end
				hep_pkg::PH_TSIZE: begin
					phase_d = ext ? hep_pkg::PH_TFLAGS : hep_pkg::PH_FIRST;
				end
				hep_pkg::PH_TFLAGS: begin
					phase_d = hep_pkg::PH_FIRST;
				end
				hep_pkg::PH_FIRST: begin
					if (v >= 32'(hep_pkg::HUNK_LIMIT)) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_RANGE;
					end else begin
						first_d = v[7:0];
						phase_d = hep_pkg::PH_LAST;
					end
				end
				hep_pkg::PH_LAST: begin
					if (v >= 32'(hep_pkg::HUNK_LIMIT)) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_RANGE;
					end else begin
						last_d  = v[7:0];
						load_d  = first_q;
						patch_d = first_q;
						used_d  = v[7:0] < first_q;
						phase_d = (v[7:0] < first_q) ? hep_pkg::PH_TYPE : hep_pkg::PH_ASIZE;
					end
				end
				hep_pkg::PH_ASIZE, hep_pkg::PH_AFLAGS: begin
					if (phase_q == hep_pkg::PH_ASIZE) begin
						pend_d = v << 2;
					end
					if (phase_q == hep_pkg::PH_ASIZE && ext) begin
						phase_d = hep_pkg::PH_AFLAGS;
					end else begin
						// Allocate the next hunk of the table.
						phase_d = hep_pkg::PH_ASIZE;
						if (load_q == last_q) begin
							load_d  = first_q;
							phase_d = hep_pkg::PH_TYPE;
						end else begin
							load_d = load_q + 8'd1;
						end
						emit    = 1'b1;
						e_act   = hep_pkg::ACT_ALLOC;
						e_hunk  = load_q;
						e_data  = pend_d;
						e_flags = (phase_q == hep_pkg::PH_ASIZE) ? {29'd0, v[31:29]} : v;
					end
				end
				hep_pkg::PH_TYPE: begin
					if (v == 32'd0) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_act   = hep_pkg::ACT_FINISH;
					end else if ((t < hep_pkg::HT_UNIT || t > hep_pkg::HT_MAX) && !t[29]) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_UNKNOWN;
					end else if (t < hep_pkg::HT_UNIT || t > hep_pkg::HT_MAX) begin
						// Unknown but marked as skippable: treated like debug.
						kind_d  = hep_pkg::KIND_DEBUG;
						phase_d = hep_pkg::PH_DBGSIZE;
					end else begin
						kind_d = 5'(t - hep_pkg::HT_UNIT);
						case (t)
							hep_pkg::HT_UNIT, hep_pkg::HT_NAME: phase_d = hep_pkg::PH_NAMELEN;
							hep_pkg::HT_CODE, hep_pkg::HT_DATA, hep_pkg::HT_BSS: begin
								if (used_q) begin
									phase_d = hep_pkg::PH_HALT;
									emit    = 1'b1;
									e_err   = hep_pkg::ERR_RANGE;
								end else begin
									phase_d = hep_pkg::PH_SEGSIZE;
								end
							end
							hep_pkg::HT_RELOC32: phase_d = hep_pkg::PH_R32COUNT;
							hep_pkg::HT_DREL32, hep_pkg::HT_RELOC32S,
							hep_pkg::HT_RELRELOC: begin
								spar_d  = 1'b0;
								phase_d = hep_pkg::PH_SCOUNT;
							end
							hep_pkg::HT_END: phase_d = hep_pkg::PH_TYPE;
							hep_pkg::HT_SYMBOL: phase_d = hep_pkg::PH_SYMLEN;
							hep_pkg::HT_RELOC16, hep_pkg::HT_RELOC8, hep_pkg::HT_DREL16,
							hep_pkg::HT_DREL8, hep_pkg::HT_HEADER, hep_pkg::HT_EXT,
							hep_pkg::HT_LIB, hep_pkg::HT_INDEX, hep_pkg::HT_OVERLAY,
							hep_pkg::HT_BREAK: begin
								phase_d = hep_pkg::PH_HALT;
								emit    = 1'b1;
								e_err   = hep_pkg::ERR_UNSUPP;
							end
							default: begin
								kind_d  = hep_pkg::KIND_DEBUG;
								phase_d = hep_pkg::PH_DBGSIZE;
							end
						endcase
					end
				end
				hep_pkg::PH_SKIP: begin
					remain_d = rem_dec;
					if (rem_dec == 32'd0) begin
						phase_d = (kind_q == hep_pkg::KIND_SYMBOL) ?
							hep_pkg::PH_SYMVAL : hep_pkg::PH_TYPE;
					end
				end
				hep_pkg::PH_NAMELEN, hep_pkg::PH_SYMLEN: begin
					remain_d = v;
					phase_d  = (v != 32'd0) ? hep_pkg::PH_SKIP : hep_pkg::PH_TYPE;
				end
				hep_pkg::PH_SYMVAL: begin
					phase_d = hep_pkg::PH_SYMLEN;
				end
				hep_pkg::PH_SEGSIZE, hep_pkg::PH_SEGFLAGS: begin
					if (phase_q == hep_pkg::PH_SEGSIZE && ext) begin
						pend_d  = v << 2;
						phase_d = hep_pkg::PH_SEGFLAGS;
					end else begin
						// The segment size comes from this long or the stored one.
						patch_d = load_q;
						if (load_q == last_q) begin
							used_d = 1'b1;
						end else begin
							load_d = load_q + 8'd1;
						end
						if (kind_q == hep_pkg::KIND_BSS) begin
							phase_d = hep_pkg::PH_TYPE;
							emit    = 1'b1;
							e_act   = hep_pkg::ACT_CLEAR;
							e_hunk  = load_q;
							e_data  = (phase_q == hep_pkg::PH_SEGSIZE) ? (v << 2) : pend_q;
						end else begin
							remain_d = (phase_q == hep_pkg::PH_SEGSIZE) ?
								{2'b00, v[29:0]} : {2'b00, pend_q[31:2]};
							offset_d = 32'd0;
							phase_d  = (remain_d != 32'd0) ? hep_pkg::PH_LOAD : hep_pkg::PH_TYPE;
						end
					end
				end
				hep_pkg::PH_LOAD: begin
					offset_d = offset_q + 32'd4;
					remain_d = rem_dec;
					if (rem_dec == 32'd0) begin
						phase_d = hep_pkg::PH_TYPE;
					end
					emit   = 1'b1;
					e_act  = hep_pkg::ACT_LOAD;
					e_hunk = patch_q;
					e_off  = offset_q;
					e_data = v;
				end
				hep_pkg::PH_R32COUNT, hep_pkg::PH_DBGSIZE: begin
					remain_d = t;
					if (ext) begin
						phase_d = (phase_q == hep_pkg::PH_R32COUNT) ?
							hep_pkg::PH_R32FLAGS : hep_pkg::PH_DBGFLAGS;
					end else if (t == 32'd0) begin
						phase_d = hep_pkg::PH_TYPE;
					end else begin
						phase_d = (phase_q == hep_pkg::PH_R32COUNT) ?
							hep_pkg::PH_R32REF : hep_pkg::PH_SKIP;
					end
				end
				hep_pkg::PH_R32FLAGS: begin
					phase_d = (remain_q != 32'd0) ? hep_pkg::PH_R32REF : hep_pkg::PH_TYPE;
				end
				hep_pkg::PH_DBGFLAGS: begin
					phase_d = (remain_q != 32'd0) ? hep_pkg::PH_SKIP : hep_pkg::PH_TYPE;
				end
				hep_pkg::PH_R32REF: begin
					if (v < {24'd0, first_q} || v > {24'd0, last_q}) begin
						phase_d = hep_pkg::PH_HALT;
						emit    = 1'b1;
						e_err   = hep_pkg::ERR_RANGE;
					end else begin
						pref_d  = v[7:0];
						phase_d = hep_pkg::PH_R32OFF;
					end
				end
				hep_pkg::PH_R32OFF: begin
					remain_d = rem_dec;
					if (rem_dec == 32'd0) begin
						phase_d = hep_pkg::PH_R32COUNT;
					end
					emit   = 1'b1;
					e_act  = hep_pkg::ACT_PATCH;
					e_hunk = patch_q;
					e_ref  = pref_q;
					e_off  = v;
				end
				default: begin
					phase_d = hep_pkg::PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hep_pkg::PH_MAGIC;
			high_q      <= 16'd0;
			parity_q    <= 1'b0;
			remain_q    <= 32'd0;
			first_q     <= 8'd0;
			last_q      <= 8'd0;
			load_q      <= 8'd0;
			patch_q     <= 8'd0;
			pref_q      <= 8'd0;
			offset_q    <= 32'd0;
			pend_q      <= 32'd0;
			spar_q      <= 1'b0;
			kind_q      <= 5'd0;
			used_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				high_q      <= high_d;
				parity_q    <= parity_d;
				remain_q    <= remain_d;
				first_q     <= first_d;
				last_q      <= last_d;
				load_q      <= load_d;
				patch_q     <= patch_d;
				pref_q      <= pref_d;
				offset_q    <= offset_d;
				pend_q      <= pend_d;
				spar_q      <= spar_d;
				kind_q      <= kind_d;
				used_q      <= used_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; loaded whenever a transaction is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= e_act;
			err_q   <= e_err;
			hunk_q  <= e_hunk;
			ref_q   <= e_ref;
			off_q   <= e_off;
			data_q  <= e_data;
			flags_q <= e_flags;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = act_q;
	assign error_code  = err_q;
	assign hunk_number = hunk_q;
	assign ref_hunk    = ref_q;
	assign byte_offset = off_q;
	assign data_value  = data_q;
	assign mem_flags   = flags_q;

	// The phase register always holds exactly one code.
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parse phase is not one-hot");

	// Once halted, no transaction produces a further action.
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == hep_pkg::PH_HALT) |=> !out_valid_q)
		else $error("action emitted after halt");

	// An error or finish action leaves the parser halted.
	a_end_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (act_q == hep_pkg::ACT_ERROR || act_q == hep_pkg::ACT_FINISH))
		|-> phase_q == hep_pkg::PH_HALT)
		else $error("terminal action without halt");

endmodule
